@@ sv/pcd_pkg.sv @@
// ---------------------------------------------------------------------------
// pcd_pkg
// Shared types and fixed constants for the polyline crossing detector.
// ---------------------------------------------------------------------------
package pcd_pkg;

  localparam int COORD_W = 16;
  localparam int HIT_W   = 6;

  localparam logic ACT_RIVER = 1'b0;
  localparam logic ACT_TRACK = 1'b1;

  // Classified work word passed from front end to back end
  typedef struct packed {
    logic                      is_track;
    logic                      first;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
  } item_t;

endpackage

@@ sv/pcd_ram.sv @@
// ---------------------------------------------------------------------------
// pcd_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module pcd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ sv/pcd_front.sv @@
// ---------------------------------------------------------------------------
// pcd_front
// Accept input words, sign-extend coordinates and classify the word kind.
// ---------------------------------------------------------------------------
module pcd_front #(
  parameter int COORD_BITS = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           in_action,
  input  logic                           in_first_point,
  input  logic signed [pcd_pkg::COORD_W-1:0] in_x_coord,
  input  logic signed [pcd_pkg::COORD_W-1:0] in_y_coord,
  output logic                           push_valid,
  input  logic                           push_ready,
  output pcd_pkg::item_t                 push_item
);

  localparam int CW = (COORD_BITS < pcd_pkg::COORD_W) ? COORD_BITS : pcd_pkg::COORD_W;

  logic                 vld_r;
  pcd_pkg::item_t       item_r;
  pcd_pkg::item_t       item_nxt;
  logic signed [CW-1:0] xs;
  logic signed [CW-1:0] ys;

  // Classify and sign-extend from the active coordinate width
  always_comb begin
    xs = in_x_coord[CW-1:0];
    ys = in_y_coord[CW-1:0];
    item_nxt.is_track = (in_action == pcd_pkg::ACT_TRACK);
    item_nxt.first    = in_first_point;
    item_nxt.x        = pcd_pkg::COORD_W'(xs);
    item_nxt.y        = pcd_pkg::COORD_W'(ys);
  end

  assign in_ready   = !vld_r || push_ready;
  assign push_valid = vld_r;
  assign push_item  = item_r;

  // Hold one word until the queue takes it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      vld_r <= 1'b1;
    end else if (push_ready) begin
      vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= item_nxt;
    end
  end

endmodule

@@ sv/pcd_queue.sv @@
// ---------------------------------------------------------------------------
// pcd_queue
// Two-entry FIFO between the front end and the back end.
// ---------------------------------------------------------------------------
module pcd_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push_valid,
  output logic           push_ready,
  input  pcd_pkg::item_t push_item,
  output logic           pop_valid,
  input  logic           pop_ready,
  output pcd_pkg::item_t pop_item
);

  pcd_pkg::item_t slot_r [2];
  logic           wptr_r;
  logic           rptr_r;
  logic [1:0]     cnt_r;
  logic           do_push;
  logic           do_pop;

  assign push_ready = (cnt_r != 2'd2);
  assign pop_valid  = (cnt_r != 2'd0);
  assign pop_item   = slot_r[rptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      if (do_push) begin
        wptr_r <= ~wptr_r;
      end
      if (do_pop) begin
        rptr_r <= ~rptr_r;
      end
      cnt_r <= cnt_r + 2'(do_push) - 2'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wptr_r] <= push_item;
    end
  end

endmodule

@@ sv/pcd_back.sv @@
// ---------------------------------------------------------------------------
// pcd_back
// Store river points and test each track segment against the stored river,
// one river segment per cycle through a four-stage arithmetic pipeline.
// ---------------------------------------------------------------------------
module pcd_back #(
  parameter int MAX_RIVER_POINTS = 64,
  parameter int COORD_BITS       = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         pop_valid,
  output logic                         pop_ready,
  input  pcd_pkg::item_t               pop_item,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         out_segment_crosses,
  output logic [pcd_pkg::HIT_W-1:0]    out_hit_index,
  output logic                         out_needs_bridge,
  output logic                         out_river_overflow
);

  localparam int CW = (COORD_BITS < pcd_pkg::COORD_W) ? COORD_BITS : pcd_pkg::COORD_W;
  localparam int DW = CW + 1;
  localparam int PW = 2 * DW;
  localparam int SW = PW + 1;
  localparam int AW = (MAX_RIVER_POINTS > 1) ? $clog2(MAX_RIVER_POINTS) : 1;
  localparam int NW = $clog2(MAX_RIVER_POINTS + 1);
  localparam int HW = pcd_pkg::HIT_W;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_OUT  = 2'd2;

  logic [1:0]           state_r;
  logic [NW-1:0]        count_r;
  logic                 ovf_r;
  logic                 started_r;
  logic                 bridge_r;
  logic signed [CW-1:0] last_x_r, last_y_r;
  logic signed [CW-1:0] a_x_r, a_y_r;
  logic signed [DW-1:0] dx1_r, dy1_r;
  logic [NW-1:0]        j_r;
  logic                 res_cross_r;
  logic [AW-1:0]        res_idx_r;

  // Pipeline registers
  logic                 v0_r, v1_r, v2_r, v3_r;
  logic [AW-1:0]        idx0_r, seg1_r, seg2_r, seg3_r;
  logic signed [CW-1:0] prev_x_r, prev_y_r;
  logic signed [DW-1:0] dx2_r, dy2_r, dx3_r, dy3_r;
  logic signed [PW-1:0] p1_r, p2_r, p3_r, p4_r, p5_r, p6_r;
  logic signed [SW-1:0] den_r, na_r, nb_r;

  logic                 out_valid_r;
  logic                 out_cross_r;
  logic [HW-1:0]        out_hit_r;
  logic                 out_bridge_r;
  logic                 out_ovf_r;

  // RAM ports
  logic                 ram_we;
  logic [AW-1:0]        ram_waddr;
  logic [2*CW-1:0]      ram_wdata;
  logic [AW-1:0]        ram_raddr;
  logic [2*CW-1:0]      ram_rdata;

  logic signed [CW-1:0] pt_x, pt_y;
  logic signed [CW-1:0] rd_x, rd_y;
  logic [NW-1:0]        base;
  logic                 issue;
  logic                 hit3;
  logic                 drained;
  logic                 finish;
  logic                 na_ok, nb_ok;
  logic [AW+HW-1:0]     idx_wide;

  assign pt_x = pop_item.x[CW-1:0];
  assign pt_y = pop_item.y[CW-1:0];
  assign rd_x = ram_rdata[2*CW-1:CW];
  assign rd_y = ram_rdata[CW-1:0];

  assign pop_ready = (state_r == S_IDLE);
  assign base      = pop_item.first ? '0 : count_r;

  // Store river points at the fill position, drop when full
  assign ram_we    = pop_valid && pop_ready && !pop_item.is_track &&
                     (base < NW'(MAX_RIVER_POINTS));
  assign ram_waddr = base[AW-1:0];
  assign ram_wdata = {pt_x, pt_y};

  pcd_ram #(
    .WIDTH (2 * CW),
    .DEPTH (MAX_RIVER_POINTS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Issue one river point read per cycle
  assign issue     = (state_r == S_SCAN) && (j_r < count_r);
  assign ram_raddr = j_r[AW-1:0];

  // Inclusive range test of both numerators against the denominator
  always_comb begin
    if (den_r > 0) begin
      na_ok = (na_r >= 0) && (na_r <= den_r);
      nb_ok = (nb_r >= 0) && (nb_r <= den_r);
    end else begin
      na_ok = (na_r <= 0) && (na_r >= den_r);
      nb_ok = (nb_r <= 0) && (nb_r >= den_r);
    end
  end

  assign hit3    = v3_r && (den_r != 0) && na_ok && nb_ok;
  assign drained = (j_r == count_r) && !v0_r && !v1_r && !v2_r && !v3_r;
  assign finish  = (state_r == S_SCAN) && (hit3 || drained);

  // Arithmetic pipeline: read, differences, products, sums
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (finish) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v0_r <= issue;
      v1_r <= v0_r && (idx0_r != '0);
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    idx0_r <= j_r[AW-1:0];
    if (v0_r) begin
      prev_x_r <= rd_x;
      prev_y_r <= rd_y;
    end
    seg1_r <= idx0_r - AW'(1);
    dx2_r  <= DW'(rd_x) - DW'(prev_x_r);
    dy2_r  <= DW'(rd_y) - DW'(prev_y_r);
    dx3_r  <= DW'(a_x_r) - DW'(prev_x_r);
    dy3_r  <= DW'(a_y_r) - DW'(prev_y_r);
    seg2_r <= seg1_r;
    p1_r   <= dy2_r * dx1_r;
    p2_r   <= dx2_r * dy1_r;
    p3_r   <= dx2_r * dy3_r;
    p4_r   <= dy2_r * dx3_r;
    p5_r   <= dx1_r * dy3_r;
    p6_r   <= dy1_r * dx3_r;
    seg3_r <= seg2_r;
    den_r  <= SW'(p1_r) - SW'(p2_r);
    na_r   <= SW'(p3_r) - SW'(p4_r);
    nb_r   <= SW'(p5_r) - SW'(p6_r);
  end

  // Sequence river stores, track scans and result hand-off
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      ovf_r       <= 1'b0;
      started_r   <= 1'b0;
      bridge_r    <= 1'b0;
      last_x_r    <= '0;
      last_y_r    <= '0;
      j_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // Drop the taken word unless a new one loads in its place
      if (out_valid_r && out_ready && (state_r != S_OUT)) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (pop_valid) begin
            if (!pop_item.is_track) begin
              if (base < NW'(MAX_RIVER_POINTS)) begin
                count_r <= base + NW'(1);
                if (pop_item.first) begin
                  ovf_r <= 1'b0;
                end
              end else begin
                ovf_r <= 1'b1;
              end
            end else begin
              last_x_r <= pt_x;
              last_y_r <= pt_y;
              if (pop_item.first || !started_r) begin
                bridge_r    <= 1'b0;
                started_r   <= 1'b1;
                res_cross_r <= 1'b0;
                res_idx_r   <= '0;
                state_r     <= S_OUT;
              end else begin
                a_x_r   <= last_x_r;
                a_y_r   <= last_y_r;
                dx1_r   <= DW'(pt_x) - DW'(last_x_r);
                dy1_r   <= DW'(pt_y) - DW'(last_y_r);
                j_r     <= '0;
                state_r <= S_SCAN;
              end
            end
          end
        end
        S_SCAN: begin
          if (issue) begin
            j_r <= j_r + NW'(1);
          end
          if (finish) begin
            res_cross_r <= hit3;
            res_idx_r   <= hit3 ? seg3_r : '0;
            if (hit3) begin
              bridge_r <= 1'b1;
            end
            state_r <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r  <= 1'b1;
            out_cross_r  <= res_cross_r;
            out_hit_r    <= idx_wide[HW-1:0];
            out_bridge_r <= bridge_r;
            out_ovf_r    <= ovf_r;
            state_r      <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign idx_wide = (AW + HW)'(res_idx_r);

  assign out_valid           = out_valid_r;
  assign out_segment_crosses = out_cross_r;
  assign out_hit_index       = out_hit_r;
  assign out_needs_bridge    = out_bridge_r;
  assign out_river_overflow  = out_ovf_r;

endmodule

@@ sv/polyline_crossing_detector.sv @@
// ---------------------------------------------------------------------------
// polyline_crossing_detector
// Stores a river polyline and flags track segments that cross it.
// ---------------------------------------------------------------------------
// River point: registered in the front end, queued, then stored; no result.
// Track point: the result word follows a scan of the N stored river points by
//   the single store read port, one river segment per cycle, which ends early
//   at a crossing; a first track point answers without a scan. One item is
//   worked on at a time in the back end.
// Reset (rst_n, synchronous): empties the queue, river count, flags and track.
// ---------------------------------------------------------------------------
module polyline_crossing_detector #(
  parameter int MAX_RIVER_POINTS = 64,
  parameter int COORD_BITS       = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               in_action,
  input  logic                               in_first_point,
  input  logic signed [pcd_pkg::COORD_W-1:0] in_x_coord,
  input  logic signed [pcd_pkg::COORD_W-1:0] in_y_coord,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               out_segment_crosses,
  output logic [pcd_pkg::HIT_W-1:0]          out_hit_index,
  output logic                               out_needs_bridge,
  output logic                               out_river_overflow
);

  logic           push_valid;
  logic           push_ready;
  pcd_pkg::item_t push_item;
  logic           pop_valid;
  logic           pop_ready;
  pcd_pkg::item_t pop_item;

  pcd_front #(
    .COORD_BITS (COORD_BITS)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_action      (in_action),
    .in_first_point (in_first_point),
    .in_x_coord     (in_x_coord),
    .in_y_coord     (in_y_coord),
    .push_valid     (push_valid),
    .push_ready     (push_ready),
    .push_item      (push_item)
  );

  pcd_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item)
  );

  pcd_back #(
    .MAX_RIVER_POINTS (MAX_RIVER_POINTS),
    .COORD_BITS       (COORD_BITS)
  ) u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .pop_valid           (pop_valid),
    .pop_ready           (pop_ready),
    .pop_item            (pop_item),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_segment_crosses (out_segment_crosses),
    .out_hit_index       (out_hit_index),
    .out_needs_bridge    (out_needs_bridge),
    .out_river_overflow  (out_river_overflow)
  );

endmodule
